// File: rtl/assert_macros.svh
// Assertion macros included by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/fse_pkg.sv
// Package: widths, codes and tables for the Fourier series evaluator
`timescale 1ns / 1ps
package fse_pkg;
	localparam int TimeW = 48;
	localparam int PerW = 47;
	localparam int CoefW = 32;
	localparam int CorrW = 34;
	localparam int StatW = 2;
	localparam int CfgIdxW = 3;
	localparam int DefHarmonics = 2;
	localparam int DefPhaseBits = 24;
	localparam int CordicSteps = 16;
	localparam logic [PerW-1:0] PeriodReset = PerW'(65536);

	typedef enum logic [CfgIdxW-1:0] {
		REG_START = 3'd0, REG_END = 3'd1, REG_CHECKS = 3'd2, REG_PERIOD = 3'd3,
		REG_C0 = 3'd4, REG_C1 = 3'd5, REG_S1 = 3'd6
	} cfg_reg_t;

	typedef enum logic [StatW-1:0] {
		ST_OK = 2'd0, ST_BEFORE = 2'd1, ST_AFTER = 2'd2
	} status_t;

	function automatic logic [31:0] atan_turn(input logic [3:0] i);
		logic [31:0] v;
		case (i)
			4'd0: v = 32'd536870912;
			4'd1: v = 32'd316933406;
			4'd2: v = 32'd167458907;
			4'd3: v = 32'd85004756;
			4'd4: v = 32'd42667331;
			4'd5: v = 32'd21354465;
			4'd6: v = 32'd10679838;
			4'd7: v = 32'd5340245;
			4'd8: v = 32'd2670163;
			4'd9: v = 32'd1335087;
			4'd10: v = 32'd667544;
			4'd11: v = 32'd333772;
			4'd12: v = 32'd166886;
			4'd13: v = 32'd83443;
			4'd14: v = 32'd41721;
			default: v = 32'd20861;
		endcase
		return v;
	endfunction
endpackage

// File: rtl/fse_if.sv
// Interfaces: valid/ready stream and configuration write channel
`timescale 1ns / 1ps
interface fse_in_if import fse_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [TimeW-1:0] sample_time;
	modport source (output valid, sample_time, input ready);
	modport sink (input valid, sample_time, output ready);
endinterface

interface fse_out_if import fse_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [CorrW-1:0] correction;
	logic [StatW-1:0] status;
	modport source (output valid, correction, status, input ready);
	modport sink (input valid, correction, status, output ready);
endinterface

interface fse_cfg_if import fse_pkg::*; ();
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/fse_mod_cell.sv
// Modulo cell: one restoring subtract step of r = d mod p
`timescale 1ns / 1ps
module fse_mod_cell import fse_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [PerW:0] r_in,
	input  logic [PerW-1:0] p_in,
	output logic [PerW:0] r_q,
	output logic [PerW-1:0] p_q
);
	logic [PerW+SHIFT:0] pw;
	logic [PerW:0] r_nx;
	always_comb begin
		pw = {{(SHIFT+1){1'b0}}, p_in} << SHIFT;
		if ({{SHIFT{1'b0}}, r_in} >= pw)
			r_nx = r_in - pw[PerW:0];
		else
			r_nx = r_in;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= r_nx;
			p_q <= p_in;
		end
	end
endmodule

// File: rtl/fse_cordic_cell.sv
// CORDIC cell: one rotation step
`timescale 1ns / 1ps
module fse_cordic_cell import fse_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [33:0] x_in,
	input  logic signed [33:0] y_in,
	input  logic signed [33:0] z_in,
	output logic signed [33:0] x_q,
	output logic signed [33:0] y_q,
	output logic signed [33:0] z_q
);
	logic signed [33:0] dx, dy, at;
	always_comb begin
		dx = y_in >>> STEP;
		dy = x_in >>> STEP;
		at = 34'(atan_turn(4'(STEP)));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[33]) begin
				x_q <= x_in - dx; y_q <= y_in + dy; z_q <= z_in - at;
			end else begin
				x_q <= x_in + dx; y_q <= y_in - dy; z_q <= z_in + at;
			end
		end
	end
endmodule

// File: rtl/fourier_series_time_eval.sv
// Fourier series evaluator at a sample time: bound check, phase, CORDIC, accumulate.
// One transaction per cycle while the output accepts; the stages in order are an input
// stage, 49 modulo cells, PHASE_BITS phase cells, angle and quadrant-fold stages, 16 CORDIC
// cells, then output mapping, products and a sum into the output register. All stages
// advance together on a global enable, held while the output waits.
`timescale 1ns / 1ps
module fourier_series_time_eval import fse_pkg::*; #(
	parameter int HARMONICS = DefHarmonics,
	parameter int PHASE_BITS = DefPhaseBits
) (
	input logic clk,
	input logic arst_n,
	fse_cfg_if.sink cfg,
	fse_in_if.sink time_ch,
	fse_out_if.source series_ch
);
	localparam int ModN = TimeW + 1;
	localparam int NH = HARMONICS - 1;
	localparam int HW = (HARMONICS > 1) ? HARMONICS - 1 : 1;
	localparam int Lat = 1 + ModN + PHASE_BITS + 1 + 1 + CordicSteps + 3;

	logic signed [TimeW-1:0] start_q, end_q;
	logic [1:0] checks_q;
	logic [PerW-1:0] period_q;
	logic signed [CoefW-1:0] c0_q, c1_q, s1_q;
	logic [Lat-1:0] vld_q;
	logic en;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0; end_q <= '0; checks_q <= '0; period_q <= PeriodReset;
			c0_q <= '0; c1_q <= '0; s1_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_START: start_q <= cfg.data[TimeW-1:0];
				REG_END: end_q <= cfg.data[TimeW-1:0];
				REG_CHECKS: checks_q <= cfg.data[1:0];
				REG_PERIOD: period_q <= cfg.data[PerW-1:0];
				REG_C0: c0_q <= cfg.data[CoefW-1:0];
				REG_C1: c1_q <= cfg.data[CoefW-1:0];
				REG_S1: s1_q <= cfg.data[CoefW-1:0];
				default: ;
			endcase
		end
	end

	assign en = !series_ch.valid || series_ch.ready;
	assign time_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], time_ch.valid};
	end
	assign series_ch.valid = vld_q[Lat-1];

	// stage 1: bounds and difference, folded to a nonnegative residue source
	logic [StatW-1:0] st_s1;
	logic neg_s1;
	logic [PerW:0] mag_s1;
	logic signed [TimeW:0] d;
	always_comb d = (TimeW+1)'(time_ch.sample_time) - (TimeW+1)'(start_q);
	always_ff @(posedge clk) begin
		if (en) begin
			if (checks_q[0] && time_ch.sample_time < start_q) st_s1 <= ST_BEFORE;
			else if (checks_q[1] && time_ch.sample_time > end_q) st_s1 <= ST_AFTER;
			else st_s1 <= ST_OK;
			neg_s1 <= d[TimeW];
			mag_s1 <= d[TimeW] ? (PerW+1)'(-d) : (PerW+1)'(d);
		end
	end

	// modulo chain
	logic [PerW:0] mr [ModN+1];
	logic [PerW-1:0] mp [ModN+1];
	logic neg_pipe [ModN+1];
	logic [StatW-1:0] st_pipe [ModN+1];
	assign mr[0] = mag_s1;
	assign mp[0] = period_q;
	assign neg_pipe[0] = neg_s1;
	assign st_pipe[0] = st_s1;
	for (genvar k = 0; k < ModN; k++) begin : g_mod
		fse_mod_cell #(.SHIFT(ModN-1-k)) u_cell (
			.clk(clk), .en(en), .r_in(mr[k]), .p_in(mp[k]),
			.r_q(mr[k+1]), .p_q(mp[k+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				neg_pipe[k+1] <= neg_pipe[k];
				st_pipe[k+1] <= st_pipe[k];
			end
		end
	end

	// phase chain: long division of r by p, one quotient bit per cell
	logic [PerW:0] rem [PHASE_BITS+1];
	logic [PerW-1:0] pp [PHASE_BITS+1];
	logic [PHASE_BITS-1:0] ph [PHASE_BITS+1];
	logic [StatW-1:0] st_ph [PHASE_BITS+1];
	always_comb begin
		if (neg_pipe[ModN] && mr[ModN] != '0) rem[0] = (PerW+1)'(mp[ModN]) - mr[ModN];
		else rem[0] = mr[ModN];
	end
	assign pp[0] = mp[ModN];
	assign ph[0] = '0;
	assign st_ph[0] = st_pipe[ModN];
	for (genvar b = 0; b < PHASE_BITS; b++) begin : g_ph
		logic [PerW+1:0] sh;
		assign sh = {rem[b], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				pp[b+1] <= pp[b];
				st_ph[b+1] <= st_ph[b];
				if (sh >= {2'b0, pp[b]}) begin
					rem[b+1] <= (PerW+1)'(sh - {2'b0, pp[b]});
					ph[b+1] <= {ph[b][PHASE_BITS-2:0], 1'b1};
				end else begin
					rem[b+1] <= sh[PerW:0];
					ph[b+1] <= {ph[b][PHASE_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// per harmonic: angle, quadrant fold
	logic [31:0] ang_s2 [HW];
	logic [StatW-1:0] st_s2, st_s3;
	logic [1:0] q_s3 [HW];
	logic signed [33:0] cx [HW][CordicSteps+1];
	logic signed [33:0] cy [HW][CordicSteps+1];
	logic signed [33:0] cz [HW][CordicSteps+1];
	logic [1:0] qp [HW][CordicSteps+1];
	logic [StatW-1:0] st_c [CordicSteps+1];
	logic [PHASE_BITS-1:0] phz;
	assign phz = (pp[PHASE_BITS] == '0) ? '0 : ph[PHASE_BITS];
	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= st_ph[PHASE_BITS];
			st_s3 <= st_s2;
		end
	end
	assign st_c[0] = st_s3;
	for (genvar h = 0; h < HW; h++) begin : g_h
		logic [PHASE_BITS+3:0] prod;
		logic [PHASE_BITS-1:0] a;
		logic [1:0] q;
		logic [31:0] zz;
		assign prod = (PHASE_BITS+4)'(phz) * (PHASE_BITS+4)'(h + 1);
		assign a = prod[PHASE_BITS-1:0];
		always_ff @(posedge clk) begin
			if (en) ang_s2[h] <= 32'({a, {(32-PHASE_BITS){1'b0}}});
		end
		always_comb begin
			q = 2'((ang_s2[h] + 32'h2000_0000) >> 30);
			zz = ang_s2[h] - {q, 30'b0};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_s3[h] <= q;
				cz[h][0] <= 34'(signed'(zz));
			end
		end
		assign cx[h][0] = 34'sd652032874;
		assign cy[h][0] = '0;
		assign qp[h][0] = q_s3[h];
		for (genvar s = 0; s < CordicSteps; s++) begin : g_c
			fse_cordic_cell #(.STEP(s)) u_cell (
				.clk(clk), .en(en), .x_in(cx[h][s]), .y_in(cy[h][s]), .z_in(cz[h][s]),
				.x_q(cx[h][s+1]), .y_q(cy[h][s+1]), .z_q(cz[h][s+1]));
			always_ff @(posedge clk) begin
				if (en) qp[h][s+1] <= qp[h][s];
			end
		end
	end
	for (genvar s = 0; s < CordicSteps; s++) begin : g_cs
		always_ff @(posedge clk) begin
			if (en) st_c[s+1] <= st_c[s];
		end
	end

	function automatic logic signed [16:0] q15(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32767) return 17'sd32767;
		if (r < -34'sd32768) return -17'sd32768;
		return 17'(r);
	endfunction

	// output mapping, products, sum
	logic signed [16:0] cosv_s4 [HW];
	logic signed [16:0] sinv_s4 [HW];
	logic signed [48:0] pc_s5 [HW];
	logic signed [48:0] ps_s5 [HW];
	logic [StatW-1:0] st_s4, st_s5, st_s6;
	logic signed [CorrW-1:0] res_s6;
	logic signed [CorrW-1:0] res_acc;
	for (genvar h = 0; h < HW; h++) begin : g_o
		logic signed [16:0] cc, ss, c, s;
		always_comb begin
			cc = q15(cx[h][CordicSteps]);
			ss = q15(cy[h][CordicSteps]);
			case (qp[h][CordicSteps])
				2'd0: begin c = cc; s = ss; end
				2'd1: begin c = -ss; s = cc; end
				2'd2: begin c = -cc; s = -ss; end
				default: begin c = ss; s = -cc; end
			endcase
			if (c > 17'sd32767) c = 17'sd32767;
			if (s > 17'sd32767) s = 17'sd32767;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cosv_s4[h] <= c;
				sinv_s4[h] <= s;
				pc_s5[h] <= (h == 0) ? 49'(c1_q) * 49'(cosv_s4[h]) : '0;
				ps_s5[h] <= (h == 0) ? 49'(s1_q) * 49'(sinv_s4[h]) : '0;
			end
		end
	end
	always_comb begin
		logic signed [52:0] acc;
		acc = 53'(c0_q) <<< 15;
		for (int h = 0; h < HW; h++) begin
			if (NH > 0) acc = acc + 53'(pc_s5[h]) + 53'(ps_s5[h]);
		end
		acc = (acc + 53'sd16384) >>> 15;
		res_acc = CorrW'(acc);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= st_c[CordicSteps];
			st_s5 <= st_s4;
			st_s6 <= st_s5;
			res_s6 <= (st_s5 == ST_OK) ? res_acc : '0;
		end
	end
	assign series_ch.correction = res_s6;
	assign series_ch.status = st_s6;
endmodule

// File: rtl/fse_checker.sv
// Port checker for the Fourier series evaluator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fse_checker import fse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [StatW-1:0] status,
	input logic signed [CorrW-1:0] correction
);
	`ASSERT_CLK(a_stat_range, clk, arst_n, out_valid |-> (status != 2'd3), "bad status")
	`ASSERT_CLK(a_err_zero, clk, arst_n, (out_valid && status != ST_OK) |-> (correction == '0), "nonzero on error")
	`ASSERT_CLK(a_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid && $stable(correction), "output dropped")
	`ASSERT_CLK(a_backp, clk, arst_n, (out_valid && !out_ready) |-> !in_ready, "accept while stalled")
endmodule

bind fourier_series_time_eval fse_checker u_fse_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(time_ch.valid), .in_ready(time_ch.ready),
	.out_valid(series_ch.valid), .out_ready(series_ch.ready), .status(series_ch.status),
	.correction(series_ch.correction));

// File: tb/fourier_series_time_eval_test.sv
// Testbench: directed table and random sample times, checked against a local series predictor
`timescale 1ns / 1ps
module fourier_series_time_eval_test;
	import fse_pkg::*;

	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
	localparam int DrainCycles = 150;
	localparam int IdleLimit = 20000;
	localparam int LongHold = 400;
	localparam int RandPhases = 6;
	localparam int ItemsPerPhase = 285;
	localparam longint PhaseMask = (64'd1 << DefPhaseBits) - 1;

	typedef struct packed {
		logic signed [CorrW-1:0] corr;
		status_t st;
	} series_res_t;

	typedef struct {
		bit is_cfg;
		logic [CfgIdxW-1:0] idx;
		logic [63:0] val;
		logic signed [TimeW-1:0] t;
		bit known;
		series_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fse_cfg_if cfg();
	fse_in_if time_ch();
	fse_out_if series_ch();

	fourier_series_time_eval dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.time_ch(time_ch.sink),
		.series_ch(series_ch.source)
	);

	always #1 clk = ~clk;

	// predictor registers
	logic signed [TimeW-1:0] start_r, end_r;
	logic [1:0] checks_r;
	logic [PerW-1:0] period_r;
	logic signed [CoefW-1:0] c0_r, c1_r, s1_r;

	logic signed [TimeW-1:0] sample_q[$];
	series_res_t series_q[$];
	int send_idx = 0;
	int errors = 0;
	int hold_req = 0;
	int idle_cycles = 0;

	const longint arctan_turn[16] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41721, 20861
	};

	function automatic longint round_q15(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	task automatic cordic_rotate(input logic [31:0] ang, output longint cv, output longint sv);
		logic [31:0] aq;
		longint q, z, x, y, dx, dy, cc, ss;
		aq = ang + 32'h2000_0000;
		q = longint'(aq[31:30]);
		z = longint'({32'b0, ang}) - q * 64'sh4000_0000;
		if (z >= 64'sh8000_0000) z = z - 64'sh1_0000_0000;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CordicSteps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - arctan_turn[i];
			end else begin
				x = x + dx; y = y - dy; z = z + arctan_turn[i];
			end
		end
		cc = round_q15(x);
		ss = round_q15(y);
		case (q)
			0: begin cv = cc; sv = ss; end
			1: begin cv = -ss; sv = cc; end
			2: begin cv = -cc; sv = -ss; end
			default: begin cv = ss; sv = -cc; end
		endcase
		if (cv > 32767) cv = 32767;
		if (sv > 32767) sv = 32767;
	endtask

	function automatic longint unsigned turn_phase(input logic signed [TimeW-1:0] t);
		longint d;
		longint unsigned p, r, m, rem, ph;
		d = longint'(t) - longint'(start_r);
		p = longint'(period_r);
		ph = 0;
		if (p == 0) return 0;
		if (d >= 0) begin
			r = longint'(d) % p;
		end else begin
			m = longint'(-d) % p;
			r = (m == 0) ? 0 : p - m;
		end
		rem = r;
		for (int b = 0; b < DefPhaseBits; b++) begin
			rem = rem << 1;
			ph = ph << 1;
			if (rem >= p) begin
				rem = rem - p;
				ph = ph | 1;
			end
		end
		return ph;
	endfunction

	task automatic predict_series(input logic signed [TimeW-1:0] t, output series_res_t res);
		longint unsigned ph;
		logic [31:0] ang;
		longint cv, sv, acc, sum;
		res.corr = '0;
		res.st = ST_OK;
		if (checks_r[0] && t < start_r) begin
			res.st = ST_BEFORE;
		end else if (checks_r[1] && t > end_r) begin
			res.st = ST_AFTER;
		end else begin
			ph = turn_phase(t);
			acc = longint'(c0_r) * 32768;
			for (int h = 1; h < DefHarmonics; h++) begin
				ang = 32'((longint'(ph) * h & PhaseMask) << (32 - DefPhaseBits));
				cordic_rotate(ang, cv, sv);
				if (h == 1) acc = acc + longint'(c1_r) * cv + longint'(s1_r) * sv;
			end
			sum = (acc + 64'sd16384) >>> 15;
			res.corr = sum[CorrW-1:0];
		end
	endtask

	function automatic void set_register(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		case (idx)
			REG_START: start_r = val[TimeW-1:0];
			REG_END: end_r = val[TimeW-1:0];
			REG_CHECKS: checks_r = val[1:0];
			REG_PERIOD: period_r = val[PerW-1:0];
			REG_C0: c0_r = val[CoefW-1:0];
			REG_C1: c1_r = val[CoefW-1:0];
			REG_S1: s1_r = val[CoefW-1:0];
			default: ;
		endcase
	endfunction

	task automatic drain_block();
		do @(posedge clk); while (series_q.size() != 0 || send_idx != sample_q.size());
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		set_register(idx, val);
		@(posedge clk);
	endtask

	task automatic queue_sample(input logic signed [TimeW-1:0] t);
		series_res_t res;
		predict_series(t, res);
		series_q = {series_q, res};
		sample_q = {sample_q, t};
	endtask

	function automatic logic signed [TimeW-1:0] pick_time();
		logic signed [TimeW-1:0] off;
		off = TimeW'(signed'($urandom_range(0, 2000)) - 1000);
		case ($urandom_range(0, 5))
			0, 1: return TimeW'({$urandom, $urandom});
			2: return start_r + off;
			3: return end_r + off;
			4: return start_r + TimeW'(longint'(period_r) * $urandom_range(0, 7)) + off;
			default: return TimeW'({$urandom, $urandom}) >>> $urandom_range(0, 40);
		endcase
	endfunction

	function automatic logic [63:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return 64'(32'h7fff_ffff);
			1: return 64'(32'h8000_0000);
			default: return 64'($urandom);
		endcase
	endfunction

	// sender: bursts and gaps
	initial begin
		int burst_left, gap;
		time_ch.valid = 1'b0;
		time_ch.sample_time = '0;
		burst_left = 0;
		forever begin
			if (send_idx < sample_q.size()) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap > 0) begin
						time_ch.valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				time_ch.valid <= 1'b1;
				time_ch.sample_time <= sample_q[send_idx];
				@(posedge clk);
				while (!time_ch.ready) @(posedge clk);
				send_idx++;
				burst_left--;
			end else begin
				time_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// receiver: stall pattern, long hold on request, result checks
	initial begin
		logic [15:0] pattern;
		int hold_left, hold_done, tick;
		series_res_t exp_res;
		series_ch.ready = 1'b0;
		pattern = 16'hffff;
		hold_left = 0;
		hold_done = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (arst_n && series_ch.valid && series_ch.ready) begin
				if (series_q.size() == 0) begin
					$error("unexpected transaction: correction %0d status %0d",
						series_ch.correction, series_ch.status);
					errors++;
				end else begin
					exp_res = series_q.pop_front();
					if (series_ch.correction !== exp_res.corr) begin
						$error("correction: expected %0d, actual %0d", exp_res.corr,
							series_ch.correction);
						errors++;
					end
					if (series_ch.status !== exp_res.st) begin
						$error("status: expected %0d, actual %0d", exp_res.st,
							series_ch.status);
						errors++;
					end
				end
			end
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = LongHold;
			end
			tick++;
			if (tick % 64 == 0)
				pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
			if (hold_left > 0) begin
				hold_left--;
				series_ch.ready <= 1'b0;
			end else begin
				series_ch.ready <= pattern[tick % 16];
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((time_ch.valid && time_ch.ready) || (series_ch.valid && series_ch.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		series_res_t zero_ok, before_r, after_r;
		logic [CfgIdxW-1:0] regs[7];
		logic [63:0] val;

		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		set_register(REG_START, '0);
		set_register(REG_END, '0);
		set_register(REG_CHECKS, '0);
		set_register(REG_PERIOD, 64'(PeriodReset));
		set_register(REG_C0, '0);
		set_register(REG_C1, '0);
		set_register(REG_S1, '0);
		zero_ok = '{corr: '0, st: ST_OK};
		before_r = '{corr: '0, st: ST_BEFORE};
		after_r = '{corr: '0, st: ST_AFTER};

		row = '{is_cfg: 0, idx: '0, val: '0, t: '0, known: 1, res: zero_ok};
		// reset state: all weights zero
		row.t = 48'sh0;               rows = {rows, row};
		row.t = 48'sh7fff_ffff_ffff;  rows = {rows, row};
		row.t = 48'sh8000_0000_0000;  rows = {rows, row};
		row.t = -48'sd1;              rows = {rows, row};
		// bound checks
		row = '{is_cfg: 1, idx: REG_END, val: 64'(100 << 16), t: '0, known: 0, res: zero_ok};
		rows = {rows, row};
		row.idx = REG_CHECKS; row.val = 64'd3; rows = {rows, row};
		row = '{is_cfg: 0, idx: '0, val: '0, t: -48'sd1, known: 1, res: before_r};
		rows = {rows, row};
		row.t = 48'sh8000_0000_0000;  rows = {rows, row};
		row.t = 48'(100 << 16) + 48'sd1; row.res = after_r; rows = {rows, row};
		row.t = 48'sh7fff_ffff_ffff;  rows = {rows, row};
		row.t = 48'(100 << 16); row.res = zero_ok; rows = {rows, row};
		// extreme weights, checks off, quarter turns
		row = '{is_cfg: 1, idx: REG_CHECKS, val: '0, t: '0, known: 0, res: zero_ok};
		rows = {rows, row};
		row.idx = REG_C0; row.val = 64'(32'h7fff_ffff); rows = {rows, row};
		row.idx = REG_C1; row.val = 64'(32'h8000_0000); rows = {rows, row};
		row.idx = REG_S1; rows = {rows, row};
		row = '{is_cfg: 0, idx: '0, val: '0, t: '0, known: 0, res: zero_ok};
		row.t = '0;              rows = {rows, row};
		row.t = 48'(1 << 14);    rows = {rows, row};
		row.t = 48'(1 << 15);    rows = {rows, row};
		row.t = 48'(3 << 14);    rows = {rows, row};
		row.t = 48'sh7fff_ffff_ffff; rows = {rows, row};
		row.t = 48'sh8000_0000_0000; rows = {rows, row};
		// zero period, unused register index
		row = '{is_cfg: 1, idx: REG_PERIOD, val: '0, t: '0, known: 0, res: zero_ok};
		rows = {rows, row};
		row.idx = RegUnused; row.val = '1; rows = {rows, row};
		row = '{is_cfg: 0, idx: '0, val: '0, t: 48'sd12345, known: 0, res: zero_ok};
		rows = {rows, row};
		// widest period and bounds, opposite weights
		row = '{is_cfg: 1, idx: REG_PERIOD, val: 64'h7fff_ffff_ffff, t: '0, known: 0,
			res: zero_ok};
		rows = {rows, row};
		row.idx = REG_START; row.val = 64'h8000_0000_0000; rows = {rows, row};
		row.idx = REG_END; row.val = 64'h7fff_ffff_ffff; rows = {rows, row};
		row.idx = REG_CHECKS; row.val = 64'd3; rows = {rows, row};
		row.idx = REG_C0; row.val = 64'(32'h8000_0000); rows = {rows, row};
		row.idx = REG_C1; row.val = 64'(32'h7fff_ffff); rows = {rows, row};
		row.idx = REG_S1; rows = {rows, row};
		row = '{is_cfg: 0, idx: '0, val: '0, t: 48'sh8000_0000_0000, known: 0, res: zero_ok};
		rows = {rows, row};
		row.t = 48'sh7fff_ffff_ffff; rows = {rows, row};
		row.t = 48'sh0000_4000_0000; rows = {rows, row};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain_block();
				write_register(rows[i].idx, rows[i].val);
			end else if (rows[i].known) begin
				series_q = {series_q, rows[i].res};
				sample_q = {sample_q, rows[i].t};
			end else begin
				queue_sample(rows[i].t);
			end
		end

		regs = '{REG_START, REG_END, REG_CHECKS, REG_PERIOD, REG_C0, REG_C1, REG_S1};
		for (int ph = 0; ph < RandPhases; ph++) begin
			drain_block();
			foreach (regs[r]) begin
				case (regs[r])
					REG_START, REG_END: val = 64'({$urandom, $urandom}) >>
						$urandom_range(8, 20);
					REG_CHECKS: val = 64'($urandom_range(0, 3));
					REG_PERIOD:
						case (ph)
							0: val = 64'd1;
							RandPhases - 1: val = 64'h7fff_ffff_ffff;
							default: val = 64'({$urandom, $urandom}) >> $urandom_range(17, 50);
						endcase
					default: val = pick_coeff();
				endcase
				if (regs[r] == REG_START || regs[r] == REG_END)
					val = 64'(TimeW'(signed'(val[39:0])));
				write_register(regs[r], val);
			end
			if (end_r < start_r && $urandom_range(0, 1)) write_register(REG_END, 64'(start_r + 1));
			for (int n = 0; n < ItemsPerPhase; n++)
				queue_sample(pick_time());
			if (ph == 1) hold_req++;
		end

		drain_block();
		if (errors == 0 && series_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
